@@ rtl/ecmt_pkg.sv @@
// shared types and constants for the entity component mask table
// no dependencies; imported by every module of the block
package ecmt_pkg;

  localparam int ENTITY_SLOTS   = 64;
  localparam int COMPONENT_BITS = 32;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int BIT_W    = 5;
  localparam int FILTER_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // table addressing follows the slot count
  localparam int ADDR_W = $clog2(ENTITY_SLOTS);

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef logic [COMPONENT_BITS-1:0] mask_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_SCAN,
    S_FINAL,
    S_EMIT
  } state_t;

  // table access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    mask_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // one result handed to the output register
  typedef struct packed {
    logic                load;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  live;
    logic                last;
  } emit_t;

endpackage

@@ rtl/ecmt_mask_ram.sv @@
// component mask table: one write port, one read port with registered data
// depends on ecmt_pkg
module ecmt_mask_ram
  import ecmt_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output mask_t    rdata
);

  mask_t mem [ENTITY_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/ecmt_ctrl.sv @@
// sequencer: command decode, set-bit read-modify-write, and the query scan
// with its single shared mask compare; depends on ecmt_pkg
module ecmt_ctrl
  import ecmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     entity_id,
  input  logic [BIT_W-1:0]    bit_index,
  input  logic                bit_value,
  input  logic [FILTER_W-1:0] filter_mask,
  input  logic                can_load,
  output emit_t               emit,
  output ram_req_t            req,
  input  mask_t               rdata
);

  state_t state, state_next;

  logic [COUNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0]   eid_q, eid_q_next;
  logic [BIT_W-1:0]    bit_q, bit_q_next;
  logic                val_q, val_q_next;
  logic [FILTER_W-1:0] filt_q, filt_q_next;
  logic [ID_W-1:0]     res_id, res_id_next;
  logic [STATUS_W-1:0] res_st, res_st_next;
  logic [COUNT_W-1:0]  issue_idx, issue_idx_next;
  logic                dv, dv_next;
  logic [ADDR_W-1:0]   cid, cid_next;
  logic                pend_v, pend_v_next;
  logic [ADDR_W-1:0]   pend_id, pend_id_next;

  logic  alloc_full;
  logic  set_bad;
  logic  match;
  logic  stall;
  logic  scan_done;
  mask_t set_mask;

  // command checks
  assign alloc_full = (count >= COUNT_W'(ENTITY_SLOTS));
  assign set_bad    = ({1'b0, entity_id} >= count) ||
                      (32'(bit_index) >= 32'(COMPONENT_BITS));

  // shared compare: entry holds every filter bit
  assign match = ((FILTER_W'(rdata) & filt_q) == filt_q);

  // hold the scan while a pending match cannot move to the output
  assign stall     = dv && match && pend_v && !can_load;
  assign scan_done = !dv && (issue_idx == count);

  // set-bit merge on the entry just read
  always_comb begin
    set_mask         = rdata;
    set_mask[bit_q]  = val_q;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd)
            CMD_SET:   state_next = set_bad ? S_EMIT : S_SET;
            CMD_QUERY: state_next = S_SCAN;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_SET:   state_next = S_EMIT;
      S_SCAN:  state_next = scan_done ? S_FINAL : S_SCAN;
      S_FINAL: state_next = can_load ? S_IDLE : S_FINAL;
      S_EMIT:  state_next = can_load ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    cmd_ready      = 1'b0;
    req            = '0;
    emit           = '0;
    emit.live      = count;
    count_next     = count;
    eid_q_next     = eid_q;
    bit_q_next     = bit_q;
    val_q_next     = val_q;
    filt_q_next    = filt_q;
    res_id_next    = res_id;
    res_st_next    = res_st;
    issue_idx_next = issue_idx;
    dv_next        = dv;
    cid_next       = cid;
    pend_v_next    = pend_v;
    pend_id_next   = pend_id;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          eid_q_next  = ADDR_W'(entity_id);
          bit_q_next  = bit_index;
          val_q_next  = bit_value;
          filt_q_next = filter_mask;
          res_id_next = '0;
          res_st_next = ST_OK;
          case (cmd)
            CMD_ALLOC: begin
              if (alloc_full) begin
                res_st_next = ST_FULL;
              end else begin
                req.we      = 1'b1;
                req.waddr   = ADDR_W'(count);
                req.wdata   = '0;
                count_next  = count + COUNT_W'(1);
                res_id_next = ID_W'(count);
              end
            end
            CMD_SET: begin
              if (set_bad) begin
                res_st_next = ST_BAD;
              end else begin
                req.re    = 1'b1;
                req.raddr = ADDR_W'(entity_id);
              end
            end
            CMD_QUERY: begin
              issue_idx_next = '0;
              dv_next        = 1'b0;
              pend_v_next    = 1'b0;
            end
            default: begin
              res_st_next = ST_BAD;
            end
          endcase
        end
      end
      S_SET: begin
        req.we    = 1'b1;
        req.waddr = eid_q;
        req.wdata = set_mask;
      end
      S_SCAN: begin
        if (!stall) begin
          // consume the entry from the last issued read
          if (dv && match) begin
            if (pend_v) begin
              emit.load   = 1'b1;
              emit.id     = ID_W'(pend_id);
              emit.status = ST_OK;
              emit.last   = 1'b0;
            end
            pend_v_next  = 1'b1;
            pend_id_next = cid;
          end
          // issue the next read
          if (issue_idx < count) begin
            req.re         = 1'b1;
            req.raddr      = ADDR_W'(issue_idx);
            cid_next       = ADDR_W'(issue_idx);
            issue_idx_next = issue_idx + COUNT_W'(1);
            dv_next        = 1'b1;
          end else begin
            dv_next = 1'b0;
          end
        end
      end
      S_FINAL: begin
        if (can_load) begin
          emit.load   = 1'b1;
          emit.id     = pend_v ? ID_W'(pend_id) : '0;
          emit.status = pend_v ? ST_OK : ST_NOMATCH;
          emit.last   = 1'b1;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          emit.load   = 1'b1;
          emit.id     = res_id;
          emit.status = res_st;
          emit.last   = 1'b1;
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      pend_v    <= 1'b0;
      issue_idx <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dv        <= dv_next;
      pend_v    <= pend_v_next;
      issue_idx <= issue_idx_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    eid_q   <= eid_q_next;
    bit_q   <= bit_q_next;
    val_q   <= val_q_next;
    filt_q  <= filt_q_next;
    res_id  <= res_id_next;
    res_st  <= res_st_next;
    cid     <= cid_next;
    pend_id <= pend_id_next;
  end

endmodule

@@ rtl/entity_component_mask_table_unit.sv @@
// Entity component mask table.
// Command channel (cmd_valid/cmd_ready) takes one command per transfer:
// allocate, set component bit, or query by filter mask. Result channel
// (res_valid/res_ready) returns result_id, status, live_count and last.
// Allocate and bad commands go straight to the result state; set bit reads
// the entry, merges the bit and writes it back, then returns its result. A
// query reads one table entry a cycle through the single read port, save
// while the scan is paused, and compares each against the filter; every
// match is a result, the final one marked with last, or one no-match result
// if nothing matched.
// cmd_ready is high only while the sequencer is idle, so one command is in
// work at a time; a command is taken while its predecessor's final result
// still sits in the output register.
// When res_ready is low the output register holds its result and the scan
// pauses on the next match until the register frees up.
// Reset clears the allocation count, the sequencer and the output valid;
// the mask table itself is not cleared, each entry is zeroed on allocation.
// Depends on ecmt_pkg, ecmt_ctrl and ecmt_mask_ram.
module entity_component_mask_table_unit
  import ecmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     entity_id,
  input  logic [BIT_W-1:0]    bit_index,
  input  logic                bit_value,
  input  logic [FILTER_W-1:0] filter_mask,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [ID_W-1:0]     result_id,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  live_count,
  output logic                last
);

  emit_t    emit;
  ram_req_t req;
  mask_t    rdata;
  logic     can_load;

  assign can_load = !res_valid || res_ready;

  ecmt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .entity_id   (entity_id),
    .bit_index   (bit_index),
    .bit_value   (bit_value),
    .filter_mask (filter_mask),
    .can_load    (can_load),
    .emit        (emit),
    .req         (req),
    .rdata       (rdata)
  );

  ecmt_mask_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit.load) begin
      result_id  <= emit.id;
      status     <= emit.status;
      live_count <= emit.live;
      last       <= emit.last;
    end
  end

endmodule

@@ dv/tb_entity_component_mask_table_unit.sv @@
`timescale 1ns / 1ps
// testbench for entity_component_mask_table_unit: directed and random commands
// checked against an in-bench table predictor; depends on ecmt_pkg and the rtl
module tb_entity_component_mask_table_unit
  import ecmt_pkg::*;
();

  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS   = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     entity_id;
    logic [BIT_W-1:0]    bit_index;
    logic                bit_value;
    logic [FILTER_W-1:0] filter_mask;
  } table_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  live;
    logic                last;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic [ID_W-1:0]     entity_id = '0;
  logic [BIT_W-1:0]    bit_index = '0;
  logic                bit_value = 1'b0;
  logic [FILTER_W-1:0] filter_mask = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [ID_W-1:0]     result_id;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  live_count;
  logic                last;

  table_cmd_t    pending_cmds[$];
  table_result_t expected_results[$];
  table_cmd_t    next_cmd;

  // predicted table contents
  mask_t model_masks[ENTITY_SLOTS];
  int    model_live = 0;

  // allocations issued so far by the stimulus builder
  int planned_live = 0;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  calm_cmd = 0;
  int  stall_left = 0;
  int  calm_res = 0;
  bit  cmd_taken = 1'b0;
  bit  res_taken = 1'b0;

  entity_component_mask_table_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .entity_id   (entity_id),
    .bit_index   (bit_index),
    .bit_value   (bit_value),
    .filter_mask (filter_mask),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .result_id   (result_id),
    .status      (status),
    .live_count  (live_count),
    .last        (last)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic queue_command(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] eid,
                               input logic [BIT_W-1:0] bidx, input logic bval,
                               input logic [FILTER_W-1:0] filt);
    table_cmd_t t;
    t.cmd = c;
    t.entity_id = eid;
    t.bit_index = bidx;
    t.bit_value = bval;
    t.filter_mask = filt;
    pending_cmds = {pending_cmds, t};
    if (c == CMD_ALLOC && planned_live < ENTITY_SLOTS) planned_live++;
  endtask

  function automatic void expect_result(input int id, input logic [STATUS_W-1:0] st,
                                        input logic fin);
    table_result_t r;
    r.id = ID_W'(id);
    r.status = st;
    r.live = COUNT_W'(model_live);
    r.last = fin;
    expected_results = {expected_results, r};
  endfunction

  // table behavior for one accepted command
  function automatic void predict_table_response(input table_cmd_t t);
    int last_hit;
    last_hit = -1;
    case (t.cmd)
      CMD_ALLOC: begin
        if (model_live >= ENTITY_SLOTS) begin
          expect_result(0, ST_FULL, 1'b1);
        end else begin
          model_masks[model_live] = '0;
          model_live++;
          expect_result(model_live - 1, ST_OK, 1'b1);
        end
      end
      CMD_SET: begin
        if (int'(t.entity_id) >= model_live || int'(t.bit_index) >= COMPONENT_BITS) begin
          expect_result(0, ST_BAD, 1'b1);
        end else begin
          model_masks[t.entity_id][t.bit_index] = t.bit_value;
          expect_result(0, ST_OK, 1'b1);
        end
      end
      CMD_QUERY: begin
        // find the final match first so it can carry last
        for (int i = 0; i < model_live; i++) begin
          if ((model_masks[i] & t.filter_mask) == t.filter_mask) last_hit = i;
        end
        if (last_hit < 0) begin
          expect_result(0, ST_NOMATCH, 1'b1);
        end else begin
          for (int i = 0; i <= last_hit; i++) begin
            if ((model_masks[i] & t.filter_mask) == t.filter_mask)
              expect_result(i, ST_OK, i == last_hit);
          end
        end
      end
      default: begin
        expect_result(0, ST_BAD, 1'b1);
      end
    endcase
  endfunction

  // command driver, changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && !cmd_taken) begin
      // hold until the transfer happens
    end else if (send_gap > 0) begin
      cmd_valid <= 1'b0;
      send_gap--;
    end else if (pending_cmds.size() > 0) begin
      next_cmd = pending_cmds.pop_front();
      cmd         <= next_cmd.cmd;
      entity_id   <= next_cmd.entity_id;
      bit_index   <= next_cmd.bit_index;
      bit_value   <= next_cmd.bit_value;
      filter_mask <= next_cmd.filter_mask;
      cmd_valid   <= 1'b1;
      // gap to insert after this command is taken
      if (calm_cmd > 0) begin
        calm_cmd--;
        send_gap = 0;
      end else begin
        send_gap = pick_gap();
        if ($urandom_range(0, 19) == 0) calm_cmd = 40;
      end
    end else begin
      cmd_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= 1'b1;
      if (calm_res > 0) begin
        calm_res--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        if ($urandom_range(0, 24) == 0) calm_res = 60;
      end
    end
  end

  // monitor: check results, predict on command transfer, watchdog
  always @(posedge clk) begin
    table_result_t exp_r;
    table_cmd_t    seen;
    cmd_taken = 1'b0;
    res_taken = 1'b0;
    if (!rst) begin
      res_taken = res_valid && res_ready;
      if (res_taken) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result id=%0d status=%0d live=%0d last=%0d",
                                    result_id, status, live_count, last));
        end else begin
          exp_r = expected_results.pop_front();
          if (result_id !== exp_r.id || status !== exp_r.status ||
              live_count !== exp_r.live || last !== exp_r.last)
            report_mismatch($sformatf(
              "got id=%0d status=%0d live=%0d last=%0d, exp id=%0d status=%0d live=%0d last=%0d",
              result_id, status, live_count, last,
              exp_r.id, exp_r.status, exp_r.live, exp_r.last));
        end
      end
      cmd_taken = cmd_valid && cmd_ready;
      if (cmd_taken) begin
        seen.cmd = cmd;
        seen.entity_id = entity_id;
        seen.bit_index = bit_index;
        seen.bit_value = bit_value;
        seen.filter_mask = filter_mask;
        predict_table_response(seen);
      end
      if (cmd_taken || res_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus, reset and end of test
  initial begin
    int                  r;
    int                  left;
    logic [CMD_W-1:0]    c;
    logic [ID_W-1:0]     eid;
    logic [BIT_W-1:0]    bidx;
    logic                bval;
    logic [FILTER_W-1:0] filt;

    // directed: empty table, bad targets, bit extremes, filter extremes
    queue_command(CMD_QUERY, '0, '0, 1'b0, '0);
    queue_command(CMD_SET, 6'd0, 5'd0, 1'b1, '0);
    queue_command(CMD_RESERVED, '0, '0, 1'b0, '0);
    queue_command(CMD_ALLOC, 6'd63, 5'd31, 1'b1, '1);
    queue_command(CMD_ALLOC, '0, '0, 1'b0, '0);
    queue_command(CMD_ALLOC, '0, '0, 1'b0, '0);
    queue_command(CMD_SET, 6'd0, 5'd31, 1'b1, '0);
    queue_command(CMD_SET, 6'd0, 5'd0, 1'b1, '0);
    queue_command(CMD_SET, 6'd1, 5'd0, 1'b1, '0);
    queue_command(CMD_SET, 6'd2, 5'd5, 1'b1, '0);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'h0000_0000);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'h0000_0001);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'h8000_0001);
    queue_command(CMD_SET, 6'd0, 5'd31, 1'b0, '0);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'h8000_0000);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'hFFFF_FFFF);
    queue_command(CMD_SET, 6'd3, 5'd0, 1'b1, '0);
    queue_command(CMD_SET, 6'd63, 5'd31, 1'b1, '1);
    queue_command(CMD_SET, 6'd2, 5'd5, 1'b0, '0);
    queue_command(CMD_QUERY, '0, '0, 1'b0, 32'h0000_0020);
    queue_command(CMD_RESERVED, 6'd63, 5'd31, 1'b1, '1);

    // random: mostly well-formed traffic over a small bit pool, filling the table
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      left = RANDOM_ITEMS - k;
      r = $urandom_range(0, 99);
      if (planned_live < ENTITY_SLOTS && left <= ENTITY_SLOTS - planned_live + 8)
        c = CMD_ALLOC;
      else if (r < 28) c = CMD_ALLOC;
      else if (r < 63) c = CMD_SET;
      else if (r < 95) c = CMD_QUERY;
      else c = CMD_RESERVED;
      if (planned_live > 0 && $urandom_range(0, 9) < 8)
        eid = ID_W'($urandom_range(0, planned_live - 1));
      else
        eid = ID_W'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 7) bidx = BIT_W'($urandom_range(0, 3));
      else bidx = BIT_W'($urandom_range(0, 31));
      bval = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 15) filt = '0;
      else if (r < 75)
        filt = (32'h1 << $urandom_range(0, 3)) |
               ($urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 3)) : 32'h0);
      else filt = $urandom();
      queue_command(c, eid, bidx, bval, filt);
    end

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for all commands and results, then let stray results show up
    while (pending_cmds.size() != 0 || cmd_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
